// ===== rtl/core/lps_pkg.sv =====
package lps_pkg;

  localparam int LED_COUNT_DEFAULT = 8;

  localparam int LED_OUT_W   = 8;
  localparam int PERIOD_W    = 16;
  localparam int LFSR_W      = 16;
  localparam int CFG_INDEX_W = 2;

  // Opcodes of an input item
  localparam logic OP_TIMER = 1'b0;
  localparam logic OP_SPEED = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LFSR_SEED   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD = 2'd2;

  // Display modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_SCAN    = 2'd1;
  localparam logic [1:0] MODE_INVERSE = 2'd2;
  localparam logic [1:0] MODE_SPARKLE = 2'd3;

  // Sparkle phases; the unused code behaves as idle
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_HOLD  = 2'd1;
  localparam logic [1:0] PHASE_CLEAR = 2'd2;

  localparam logic [LFSR_W-1:0]   LFSR_MASK    = 16'hB400;
  localparam logic [LFSR_W-1:0]   SEED_DEFAULT = 16'hA5A5;
  localparam logic [PERIOD_W-1:0] SLOW_DEFAULT = 16'd1000;
  localparam logic [PERIOD_W-1:0] FAST_DEFAULT = 16'd500;

  localparam int HOLD_MIN  = 100;
  localparam int HOLD_MAX  = 1500;
  localparam int HOLD_SPAN = HOLD_MAX - HOLD_MIN + 1;
  localparam int GAP_MIN   = 1;
  localparam int GAP_SPAN  = 100;

  // floor(2^SHIFT / SPAN); the estimated quotient is at most one short
  localparam int HOLD_SHIFT = 26;
  localparam logic [31:0] HOLD_RECIP = 32'((64'd1 << HOLD_SHIFT) / HOLD_SPAN);
  localparam int GAP_SHIFT = 22;
  localparam logic [31:0] GAP_RECIP = 32'((64'd1 << GAP_SHIFT) / GAP_SPAN);

  typedef struct packed {
    logic opcode;
    logic press_scan;
    logic press_inverse;
    logic press_sparkle;
    logic press_speed;
  } item_t;

  typedef struct packed {
    logic [LED_OUT_W-1:0] leds;
    logic [PERIOD_W-1:0]  period_ms;
    logic                 period_load;
    logic [1:0]           active_mode;
    logic                 fast_on;
  } result_t;

  typedef struct packed {
    logic                   wr;
    logic [CFG_INDEX_W-1:0] index;
    logic [LFSR_W-1:0]      data;
  } cfg_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    return v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
  endfunction

  // HOLD_MIN + v mod HOLD_SPAN by reciprocal multiply and one correction
  function automatic logic [PERIOD_W-1:0] hold_period(input logic [LFSR_W-1:0] v);
    logic [31:0] prod;
    logic [5:0]  q;
    logic [16:0] r;
    prod = 32'(v) * HOLD_RECIP;
    q    = 6'(prod >> HOLD_SHIFT);
    r    = 17'(v) - 17'(q) * 17'(HOLD_SPAN);
    if (r >= 17'(HOLD_SPAN)) begin
      r = r - 17'(HOLD_SPAN);
    end
    return PERIOD_W'(r + 17'(HOLD_MIN));
  endfunction

  // GAP_MIN + v mod GAP_SPAN
  function automatic logic [PERIOD_W-1:0] gap_period(input logic [LFSR_W-1:0] v);
    logic [31:0] prod;
    logic [9:0]  q;
    logic [16:0] r;
    prod = 32'(v) * GAP_RECIP;
    q    = 10'(prod >> GAP_SHIFT);
    r    = 17'(v) - 17'(q) * 17'(GAP_SPAN);
    if (r >= 17'(GAP_SPAN)) begin
      r = r - 17'(GAP_SPAN);
    end
    return PERIOD_W'(r + 17'(GAP_MIN));
  endfunction

endpackage

// ===== rtl/core/lps_if.sv =====
interface lps_item_if;
  logic valid;
  logic ready;
  logic opcode;
  logic press_scan;
  logic press_inverse;
  logic press_sparkle;
  logic press_speed;

  modport source (
    output valid, opcode, press_scan, press_inverse, press_sparkle, press_speed,
    input  ready
  );
  modport sink (
    input  valid, opcode, press_scan, press_inverse, press_sparkle, press_speed,
    output ready
  );
endinterface

interface lps_result_if;
  import lps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LED_OUT_W-1:0] leds;
  logic [PERIOD_W-1:0]  period_ms;
  logic                 period_load;
  logic [1:0]           active_mode;
  logic                 fast_on;

  modport source (
    output valid, leds, period_ms, period_load, active_mode, fast_on,
    input  ready
  );
  modport sink (
    input  valid, leds, period_ms, period_load, active_mode, fast_on,
    output ready
  );
endinterface

interface lps_cfg_if;
  import lps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LFSR_W-1:0]      data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/led_pattern_sequencer_top.sv =====
// Channel  | Dir | Payload                                           | Transfer
// ---------+-----+---------------------------------------------------+------------------
// item     | in  | opcode, press_scan/inverse/sparkle/speed          | valid & ready
// result   | out | leds, period_ms, period_load, active_mode, fast_on | valid & ready
// cfg      | in  | index (0 seed, 1 slow, 2 fast), data              | valid & ready
//
// One result per item; an item can enter every cycle while results are taken.
// Its result passes through the hold register and then the result register
// before it is offered for transfer.
// The event logic is a single short pass between those two registers.
// rst is synchronous: all state, the period registers and the random generator reload.
// A stalled result holds the result register; one further item waits in the
// hold register before item.ready drops. cfg is always ready.
module led_pattern_sequencer_top #(
  parameter int LED_COUNT = lps_pkg::LED_COUNT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  lps_item_if.sink      item,
  lps_result_if.source  result,
  lps_cfg_if.sink       cfg
);
  import lps_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    out_valid;
  result_t out_data;
  result_t step_result;
  cfg_t    cfg_w;
  logic    advance;

  // Move the held item into the result register whenever that register is
  // free or being emptied this cycle.
  assign advance    = hold_valid && (!out_valid || result.ready);
  assign item.ready = !hold_valid || advance;
  assign cfg.ready  = 1'b1;

  assign cfg_w.wr    = cfg.valid;
  assign cfg_w.index = cfg.index;
  assign cfg_w.data  = cfg.data;

  lps_engine #(
    .LED_COUNT (LED_COUNT)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .cfg    (cfg_w),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (item.ready) begin
        hold_valid <= item.valid;
      end
      // fill on advance, drop once the result transfer completes
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_item.opcode        <= item.opcode;
      hold_item.press_scan    <= item.press_scan;
      hold_item.press_inverse <= item.press_inverse;
      hold_item.press_sparkle <= item.press_sparkle;
      hold_item.press_speed   <= item.press_speed;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign result.valid       = out_valid;
  assign result.leds        = out_data.leds;
  assign result.period_ms   = out_data.period_ms;
  assign result.period_load = out_data.period_load;
  assign result.active_mode = out_data.active_mode;
  assign result.fast_on     = out_data.fast_on;

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> hold_valid)
    else $error("accepted item not held");

  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.period_load |-> out_data.period_ms != '0)
    else $error("zero timer period requested");

  a_noload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.period_load |-> out_data.period_ms == '0)
    else $error("period given without a load request");
`endif

endmodule

// ===== rtl/core/lps_engine.sv =====
module lps_engine #(
  parameter int LED_COUNT = lps_pkg::LED_COUNT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lps_pkg::item_t   item,
  input  lps_pkg::cfg_t    cfg,
  output lps_pkg::result_t result
);
  import lps_pkg::*;

  localparam int POS_W  = $clog2(LED_COUNT);
  localparam int CPOS_W = $clog2(LED_COUNT + 1);
  localparam int TOP    = LED_COUNT - 1;

  logic [PERIOD_W-1:0]  slow_period_ms;
  logic [PERIOD_W-1:0]  fast_period_ms;

  logic [1:0]           mode_reg,       mode_next;
  logic [POS_W-1:0]     scan_position,  pos_next;
  logic                 scan_down,      down_next;
  logic                 fast_select,    fast_next;
  logic                 speed_armed,    armed_next;
  logic [1:0]           sparkle_phase,  phase_next;
  logic [LED_COUNT-1:0] sparkle_bits,   bits_next;
  logic [CPOS_W-1:0]    clear_position, cpos_next;
  logic [LFSR_W-1:0]    lfsr_value,     lfsr_next;
  logic [LED_COUNT-1:0] led_reg,        led_next;

  logic [LFSR_W-1:0]    lfsr_one, lfsr_two;
  logic [PERIOD_W-1:0]  speed_cur, speed_tog;
  logic                 load;
  logic [PERIOD_W-1:0]  period;
  logic                 found;
  logic [POS_W-1:0]     hit;
  logic [POS_W:0]       pos_up;
  logic [15:0]          led_wide;

  function automatic logic [PERIOD_W-1:0] nonzero(input logic [PERIOD_W-1:0] p);
    return (p == '0) ? PERIOD_W'(1) : p;
  endfunction

  assign lfsr_one  = lfsr_step(lfsr_value);
  assign lfsr_two  = lfsr_step(lfsr_one);
  assign speed_cur = nonzero(fast_select ? fast_period_ms : slow_period_ms);
  assign speed_tog = nonzero(fast_select ? slow_period_ms : fast_period_ms);

  // lowest lit sparkle bit at or above the clear position
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = LED_COUNT - 1; i >= 0; i--) begin
      if (sparkle_bits[i] && (i >= int'(clear_position))) begin
        found = 1'b1;
        hit   = POS_W'(i);
      end
    end
  end

  always_comb begin
    mode_next  = mode_reg;
    pos_next   = scan_position;
    down_next  = scan_down;
    fast_next  = fast_select;
    armed_next = speed_armed;
    phase_next = sparkle_phase;
    bits_next  = sparkle_bits;
    cpos_next  = clear_position;
    lfsr_next  = lfsr_value;
    led_next   = led_reg;
    load       = 1'b0;
    period     = '0;
    pos_up     = '0;

    if (item.opcode == OP_TIMER) begin
      if (item.press_scan) begin
        mode_next = MODE_SCAN;
        pos_next  = '0;
        down_next = 1'b0;
        load      = 1'b1;
        period    = speed_cur;
      end
      if (item.press_inverse) begin
        mode_next = MODE_INVERSE;
        pos_next  = '0;
        down_next = 1'b0;
        load      = 1'b1;
        period    = speed_cur;
      end
      if (item.press_sparkle) begin
        mode_next  = MODE_SPARKLE;
        phase_next = PHASE_IDLE;
        cpos_next  = '0;
      end

      case (mode_next)
        MODE_SCAN, MODE_INVERSE: begin
          if (mode_next == MODE_SCAN) begin
            led_next = LED_COUNT'(1) << pos_next;
          end else begin
            led_next = ~(LED_COUNT'(1) << pos_next);
          end
          // bounce without repeating the end LED
          if (down_next) begin
            if (pos_next == '0) begin
              down_next = 1'b0;
            end else begin
              pos_next = pos_next - POS_W'(1);
              if (pos_next == '0) begin
                down_next = 1'b0;
              end
            end
          end else begin
            pos_up = {1'b0, pos_next} + (POS_W+1)'(1);
            if (pos_up >= (POS_W+1)'(TOP)) begin
              pos_next  = POS_W'(TOP);
              down_next = 1'b1;
            end else begin
              pos_next = pos_up[POS_W-1:0];
            end
          end
        end
        MODE_SPARKLE: begin
          case (phase_next)
            PHASE_HOLD: begin
              phase_next = PHASE_CLEAR;
              lfsr_next  = lfsr_one;
              load       = 1'b1;
              period     = gap_period(lfsr_one);
            end
            PHASE_CLEAR: begin
              if (found) begin
                bits_next = sparkle_bits & ~(LED_COUNT'(1) << hit);
                led_next  = bits_next;
                cpos_next = CPOS_W'(hit) + CPOS_W'(1);
                lfsr_next = lfsr_one;
                load      = 1'b1;
                period    = gap_period(lfsr_one);
              end else begin
                cpos_next  = CPOS_W'(LED_COUNT);
                phase_next = PHASE_IDLE;
              end
            end
            default: begin
              bits_next  = LED_COUNT'(lfsr_one[7:0]);
              led_next   = bits_next;
              lfsr_next  = lfsr_two;
              load       = 1'b1;
              period     = hold_period(lfsr_two);
              cpos_next  = '0;
              phase_next = PHASE_HOLD;
            end
          endcase
        end
        default: begin
          led_next = '0;
        end
      endcase
    end else if (mode_reg != MODE_SPARKLE) begin
      if (item.press_speed && speed_armed) begin
        armed_next = 1'b0;
        fast_next  = ~fast_select;
        load       = 1'b1;
        period     = speed_tog;
      end else if (!item.press_speed) begin
        armed_next = 1'b1;
      end
    end
  end

  assign led_wide = 16'(led_next);

  assign result.leds        = led_wide[LED_OUT_W-1:0];
  assign result.period_ms   = period;
  assign result.period_load = load;
  assign result.active_mode = mode_next;
  assign result.fast_on     = fast_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period_ms <= SLOW_DEFAULT;
      fast_period_ms <= FAST_DEFAULT;
      mode_reg       <= MODE_OFF;
      scan_position  <= '0;
      scan_down      <= 1'b0;
      fast_select    <= 1'b0;
      speed_armed    <= 1'b1;
      sparkle_phase  <= PHASE_IDLE;
      sparkle_bits   <= '0;
      clear_position <= '0;
      lfsr_value     <= SEED_DEFAULT;
      led_reg        <= '0;
    end else begin
      if (step) begin
        mode_reg       <= mode_next;
        scan_position  <= pos_next;
        scan_down      <= down_next;
        fast_select    <= fast_next;
        speed_armed    <= armed_next;
        sparkle_phase  <= phase_next;
        sparkle_bits   <= bits_next;
        clear_position <= cpos_next;
        led_reg        <= led_next;
      end
      // a seed write takes over the generator
      if (cfg.wr && cfg.index == REG_LFSR_SEED) begin
        lfsr_value <= (cfg.data == '0) ? SEED_DEFAULT : cfg.data;
      end else if (step) begin
        lfsr_value <= lfsr_next;
      end
      if (cfg.wr) begin
        case (cfg.index)
          REG_SLOW_PERIOD: slow_period_ms <= cfg.data;
          REG_FAST_PERIOD: fast_period_ms <= cfg.data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr_value != '0)
    else $error("random generator reached the all-zero lock state");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_position <= POS_W'(TOP))
    else $error("scan position beyond the top LED");

  a_sparkle_speed: assert property (@(posedge clk) disable iff (rst)
    step && item.opcode == OP_SPEED && mode_reg == MODE_SPARKLE |=> $stable(fast_select))
    else $error("speed toggled while in sparkle mode");
`endif

endmodule
